// ===== hw/rtl/tpid_pkg.sv =====
// Package with the shared types, codes and constants of the timed PID turn controller.
package tpid_pkg;

  // Control period of one tick transaction, in milliseconds.
  localparam int unsigned TICK_MS = 10;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CFG_TARGET   = 3'd0,
    CFG_CLOCKWISE = 3'd1,
    CFG_DURATION = 3'd2,
    CFG_GAIN_P   = 3'd3,
    CFG_GAIN_I   = 3'd4,
    CFG_GAIN_D   = 3'd5
  } cfg_idx_e;

  // What a result turns out to be: start acknowledge, window ended, or a control step.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_RUN   = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [15:0] target_angle;
    logic               turn_clockwise;
    logic        [15:0] duration_ms;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
  } cfg_t;

  // Front stage: error, derivative and updated integral.
  typedef struct packed {
    kind_e              kind;
    logic signed [25:0] err;
    logic signed [26:0] der;
    logic signed [47:0] sum;
  } s1_t;

  // Multiplier stage: the three gain products, integral split in two halves.
  typedef struct packed {
    kind_e              kind;
    logic signed [57:0] mp;
    logic signed [58:0] md;
    logic signed [56:0] mi_lo;
    logic signed [55:0] mi_hi;
  } s2_t;

  // Partial sums stage.
  typedef struct packed {
    kind_e              kind;
    logic signed [59:0] t_pd;
    logic signed [80:0] t_i;
  } s3_t;

  typedef struct packed {
    logic signed [15:0] left_power;
    logic signed [15:0] right_power;
    logic               done_res;
  } res_t;

endpackage

// ===== hw/rtl/tpid_in_if.sv =====
// Input channel interface: operation code and heading sample.
interface tpid_in_if import tpid_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [23:0] heading_sample;

  modport source (output valid, output operation, output heading_sample, input ready);
  modport sink (input valid, input operation, input heading_sample, output ready);
endinterface

// ===== hw/rtl/tpid_out_if.sv =====
// Output channel interface: left and right drive power and the done flag.
interface tpid_out_if import tpid_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [15:0] left_power;
  logic signed [15:0] right_power;
  logic               done_res;

  modport source (output valid, output left_power, output right_power, output done_res,
                  input ready);
  modport sink (input valid, input left_power, input right_power, input done_res,
                output ready);
endinterface

// ===== hw/rtl/tpid_front.sv =====
// Front stage: configuration registers, controller state and error/integral update.
module tpid_front import tpid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               operation_i,
  input  logic signed [23:0] heading_sample_i,
  output logic               valid_o,
  input  logic               ready_i,
  output s1_t                data_o,
  output cfg_t               cfg_o
);

  localparam logic [16:0] TickMs = 17'(TICK_MS);
  localparam logic signed [47:0] SumMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SumMin = {1'b1, {47{1'b0}}};

  cfg_t               cfg_q;
  logic signed [23:0] offset_q;
  logic        [16:0] elapsed_q;
  logic signed [25:0] last_q;
  logic signed [47:0] sum_q;
  logic               valid_q;
  s1_t                data_q;
  s1_t                data_d;

  logic signed [24:0] rel;
  logic signed [23:0] tgt;
  logic signed [25:0] err;
  logic signed [26:0] der;
  logic signed [48:0] sum_w;
  logic signed [47:0] sum_sat;
  logic               active;
  logic               accept;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    rel    = 25'(heading_sample_i) - 25'(offset_q);
    tgt    = {cfg_q.target_angle, 8'h00};
    err    = 26'(tgt) - 26'(rel);
    der    = 27'(err) - 27'(last_q);
    sum_w  = 49'(sum_q) + 49'(err);
    if (sum_w[48] != sum_w[47]) begin
      sum_sat = sum_w[48] ? SumMin : SumMax;
    end else begin
      sum_sat = sum_w[47:0];
    end
    active = elapsed_q < {1'b0, cfg_q.duration_ms};
    data_d.err = err;
    data_d.der = der;
    data_d.sum = sum_sat;
    if (op_e'(operation_i) == OP_START) begin
      data_d.kind = KIND_START;
    end else if (active) begin
      data_d.kind = KIND_RUN;
    end else begin
      data_d.kind = KIND_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_angle   <= '0;
      cfg_q.turn_clockwise <= 1'b1;
      cfg_q.duration_ms    <= '0;
      cfg_q.gain_p         <= '0;
      cfg_q.gain_i         <= '0;
      cfg_q.gain_d         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET:    cfg_q.target_angle   <= cfg_data_i[15:0];
        CFG_CLOCKWISE: cfg_q.turn_clockwise <= cfg_data_i[0];
        CFG_DURATION:  cfg_q.duration_ms    <= cfg_data_i[15:0];
        CFG_GAIN_P:    cfg_q.gain_p         <= cfg_data_i;
        CFG_GAIN_I:    cfg_q.gain_i         <= cfg_data_i;
        CFG_GAIN_D:    cfg_q.gain_d         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      elapsed_q <= '0;
      last_q    <= '0;
      sum_q     <= '0;
    end else if (accept) begin
      case (data_d.kind)
        KIND_START: begin
          offset_q  <= heading_sample_i;
          elapsed_q <= '0;
          last_q    <= '0;
          sum_q     <= '0;
        end
        KIND_RUN: begin
          elapsed_q <= elapsed_q + TickMs;
          last_q    <= err;
          sum_q     <= sum_sat;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign cfg_o   = cfg_q;

endmodule

// ===== hw/rtl/tpid_mult.sv =====
// Multiplier stage: the proportional, derivative and split integral products.
module tpid_mult import tpid_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  output logic ready_o,
  input  s1_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s2_t  data_o
);

  logic valid_q;
  s2_t  data_q;
  s2_t  data_d;

  assign ready_o = !valid_q || ready_i;

  // The 48-bit integral is multiplied as an unsigned low half and a signed high half.
  always_comb begin
    data_d.kind  = data_i.kind;
    data_d.mp    = data_i.err * cfg_i.gain_p;
    data_d.md    = data_i.der * cfg_i.gain_d;
    data_d.mi_lo = $signed({1'b0, data_i.sum[23:0]}) * cfg_i.gain_i;
    data_d.mi_hi = $signed(data_i.sum[47:24]) * cfg_i.gain_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/tpid_acc.sv =====
// Partial sum stage: proportional plus derivative, and the recombined integral product.
module tpid_acc import tpid_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  s2_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s3_t  data_o
);

  logic valid_q;
  s3_t  data_q;
  s3_t  data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.kind = data_i.kind;
    data_d.t_pd = 60'(data_i.mp) + 60'(data_i.md);
    data_d.t_i  = (81'(data_i.mi_hi) <<< 24) + 81'(data_i.mi_lo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/tpid_out.sv =====
// Result stage: final sum, clamp to plus or minus 1.0, Q2.14 conversion and side selection.
module tpid_out import tpid_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  output logic ready_o,
  input  s3_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  localparam logic signed [80:0] PwrMax = 81'sd16777216;
  localparam logic signed [80:0] PwrMin = -81'sd16777216;

  logic               valid_q;
  res_t               data_q;
  res_t               data_d;
  logic signed [80:0] acc;
  logic signed [80:0] clamped;
  logic signed [15:0] power;
  logic signed [15:0] power_neg;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    acc = data_i.t_i + 81'(data_i.t_pd);
    if (acc > PwrMax) begin
      clamped = PwrMax;
    end else if (acc < PwrMin) begin
      clamped = PwrMin;
    end else begin
      clamped = acc;
    end
    // Arithmetic shift rounds toward minus infinity.
    power     = 16'(clamped >>> 10);
    power_neg = -power;
    data_d.done_res = (data_i.kind == KIND_DONE);
    if (data_i.kind == KIND_RUN) begin
      data_d.left_power  = cfg_i.turn_clockwise ? power : power_neg;
      data_d.right_power = cfg_i.turn_clockwise ? power_neg : power;
    end else begin
      data_d.left_power  = '0;
      data_d.right_power = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/timed_pid_turn_controller.sv =====
// Top level of the timed PID turn controller: four-stage pipeline behind two stream channels.
//
//   Channel   Dir   Handshake        Payload
//   req_i     in    valid / ready    operation, heading_sample (Q15.8)
//   rsp_o     out   valid / ready    left_power, right_power (Q2.14), done_res
//   cfg_*     in    cfg_we_i only    cfg_idx_i selects the register, cfg_data_i holds the value
//
// One transaction is accepted per cycle unless the input stalls; each yields one result.
// The controller state (offset, elapsed time, last error, integral) is updated in the cycle
// of acceptance, so consecutive ticks need no gap; the gain products follow in the pipeline.
// Reset clears all state and loads the register defaults at once; no clearing pass is needed.
// Each stage holds its item while the next one is full, so a stalled result back-pressures
// the input only after the empty stages in between have filled.
module timed_pid_turn_controller import tpid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  tpid_in_if.sink     req_i,
  tpid_out_if.source  rsp_o
);

  cfg_t cfg;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;
  res_t res_data;

  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic s3_valid, s3_ready;

  // Front stage: the heading sample becomes an error against the tared offset, and the
  // integral and derivative are formed right away so the next tick can follow directly.
  tpid_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .valid_i          (req_i.valid),
    .ready_o          (req_i.ready),
    .operation_i      (req_i.operation),
    .heading_sample_i (req_i.heading_sample),
    .valid_o          (s1_valid),
    .ready_i          (s1_ready),
    .data_o           (s1_data),
    .cfg_o            (cfg)
  );

  // Gain products; the 48-bit integral is handled as two halves of at most 32 by 25 bits.
  tpid_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // Partial sums, kept exact so the final clamp sees the full-precision total.
  tpid_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  // Result register: clamp, convert to Q2.14 and give the sides opposite signs.
  tpid_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .data_i  (s3_data),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .data_o  (res_data)
  );

  assign rsp_o.left_power  = res_data.left_power;
  assign rsp_o.right_power = res_data.right_power;
  assign rsp_o.done_res    = res_data.done_res;

endmodule

// ===== hw/rtl/tpid_checker.sv =====
// Port-level assertions for the timed PID turn controller and the bind that attaches them.
module tpid_checker import tpid_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] left_power_i,
  input logic signed [15:0] right_power_i,
  input logic               done_res_i
);

  logic [2:0] inflight_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // The two sides always get opposite power.
  a_opposite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> right_power_i == -left_power_i)
    else $error("left and right power are not opposite");

  // A finished window drives both sides to zero.
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> left_power_i == 16'sd0 && right_power_i == 16'sd0)
    else $error("power not zero after the window ended");

  // With the result register empty, every stage can move, so the input is ready.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty pipeline");

  // No more than four items in flight, and no result without a pending transaction.
  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4 && (!out_valid_i || inflight_q != 3'd0))
    else $error("result count does not match accepted transactions");

endmodule

bind timed_pid_turn_controller tpid_checker u_tpid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .left_power_i  (rsp_o.left_power),
  .right_power_i (rsp_o.right_power),
  .done_res_i    (rsp_o.done_res)
);

// ===== verif/timed_pid_turn_controller_tb.sv =====
// Self-checking testbench of the timed PID turn controller with a class-based power predictor.
`timescale 1ns / 1ps

module timed_pid_turn_controller_tb;
  import tpid_pkg::*;

  // The run ends with a failure if it is still going after this many nanoseconds.
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;
  // Twenty directed items come first; the random part stops after roughly this many more.
  localparam int unsigned DIRECTED_ITEMS = 20;
  localparam int unsigned RANDOM_ITEMS   = 690;
  // Past this count no side idles any more.
  localparam int unsigned QUIET_FROM     = 650;
  // The final wait after the last result leaves room to catch any extra result.
  localparam int unsigned DRAIN_CYCLES   = 8;

  // Tracks the controller state, predicts the drive power of every accepted request
  // transaction and compares each result transaction against the oldest prediction.
  class turn_power_checker;
    localparam longint INTEG_HI   = (longint'(1) <<< 47) - 1;
    localparam longint INTEG_LO   = -(longint'(1) <<< 47);
    localparam longint I_TERM_LIM = longint'(1) <<< 60;
    localparam longint POWER_FS   = longint'(16384) * 1024;

    cfg_t               regs;
    logic signed [23:0] heading_zero;
    logic        [16:0] ms_since_start;
    logic signed [25:0] prev_err;
    logic signed [47:0] err_integ;
    res_t               power_q[$];
    int unsigned        mismatch_cnt;

    function new();
      regs                = '0;
      regs.turn_clockwise = 1'b1;
      heading_zero        = '0;
      ms_since_start      = '0;
      prev_err            = '0;
      err_integ           = '0;
      mismatch_cnt        = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_TARGET:    regs.target_angle   = data[15:0];
        CFG_CLOCKWISE: regs.turn_clockwise = data[0];
        CFG_DURATION:  regs.duration_ms    = data[15:0];
        CFG_GAIN_P:    regs.gain_p         = data;
        CFG_GAIN_I:    regs.gain_i         = data;
        CFG_GAIN_D:    regs.gain_d         = data;
        default: ;
      endcase
    endfunction

    function void note_request(op_e op, logic signed [23:0] sample);
      res_t                res;
      longint              err;
      longint              der;
      longint              integ;
      longint              i_term;
      longint              acc;
      logic signed [127:0] i_prod;
      logic signed [15:0]  power;
      res = '0;
      if (op == OP_START) begin
        heading_zero   = sample;
        ms_since_start = '0;
        prev_err       = '0;
        err_integ      = '0;
      end else if (ms_since_start >= regs.duration_ms) begin
        res.done_res = 1'b1;
      end else begin
        // Error in Q17.8: the target in whole degrees against the rotation since the start.
        err = longint'(signed'(regs.target_angle)) * 256
              - (longint'(sample) - longint'(heading_zero));
        der = err - longint'(prev_err);
        prev_err = err[25:0];
        integ = longint'(err_integ) + err;
        if (integ > INTEG_HI) begin
          integ = INTEG_HI;
        end else if (integ < INTEG_LO) begin
          integ = INTEG_LO;
        end
        err_integ = integ[47:0];
        // The integral term can exceed 64 bits before it is limited.
        i_prod = 128'(signed'(regs.gain_i)) * 128'(integ);
        if (i_prod > I_TERM_LIM) begin
          i_term = I_TERM_LIM;
        end else if (i_prod < -I_TERM_LIM) begin
          i_term = -I_TERM_LIM;
        end else begin
          i_term = longint'(i_prod);
        end
        acc = longint'(signed'(regs.gain_p)) * err + longint'(signed'(regs.gain_d)) * der
              + i_term;
        if (acc > POWER_FS) begin
          acc = POWER_FS;
        end else if (acc < -POWER_FS) begin
          acc = -POWER_FS;
        end
        // Q.24 to Q2.14, rounding toward minus infinity.
        power = 16'(acc >>> 10);
        res.left_power  = regs.turn_clockwise ? power : -power;
        res.right_power = regs.turn_clockwise ? -power : power;
        ms_since_start  = ms_since_start + 17'(TICK_MS);
      end
      power_q.push_back(res);
    endfunction

    function void check_power(logic signed [15:0] left_pwr, logic signed [15:0] right_pwr,
                              logic done_flag);
      res_t want;
      if (power_q.size() == 0) begin
        $error("result with no request pending: left_power %0d, right_power %0d, done_res %0b",
               left_pwr, right_pwr, done_flag);
        mismatch_cnt++;
        return;
      end
      want = power_q.pop_front();
      if (left_pwr !== want.left_power) begin
        $error("left_power: expected %0d, actual %0d", $signed(want.left_power), left_pwr);
        mismatch_cnt++;
      end
      if (right_pwr !== want.right_power) begin
        $error("right_power: expected %0d, actual %0d", $signed(want.right_power), right_pwr);
        mismatch_cnt++;
      end
      if (done_flag !== want.done_res) begin
        $error("done_res: expected %0b, actual %0b", want.done_res, done_flag);
        mismatch_cnt++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  tpid_in_if  req_if ();
  tpid_out_if rsp_if ();

  turn_power_checker power_chk;
  cfg_t              cur_cfg;
  int unsigned       items_sent = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;

  timed_pid_turn_controller i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  // Outputs are sampled on the falling edge, half a cycle away from the edge that moves them.
  // A result seen valid and ready here is taken at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid && rsp_if.ready) begin
      power_chk.check_power(rsp_if.left_power, rsp_if.right_power, rsp_if.done_res);
    end
  end

  // Result side back-pressure: random stall bursts while the current phase allows them.
  initial begin
    rsp_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Offers one request transaction, possibly after an idle burst, and returns at the rising
  // edge that accepts it. The ready seen at the falling edge before holds through that edge.
  task automatic send_request(op_e op, logic signed [23:0] sample);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.operation      <= op;
    req_if.heading_sample <= sample;
    do @(negedge clk_i); while (!req_if.ready);
    @(posedge clk_i);
    power_chk.note_request(op, sample);
    items_sent++;
  endtask

  // Stops sending and waits until every predicted result has come back. Since each request
  // yields a result, the block is idle at that point and registers may be written.
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (power_chk.power_q.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    power_chk.set_register(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes all six registers with junk in the unused upper bits, then an index past the
  // last register, which the block has to ignore.
  task automatic load_config(cfg_t c);
    cur_cfg = c;
    write_reg(CFG_TARGET, {16'($urandom), c.target_angle});
    write_reg(CFG_CLOCKWISE, {31'($urandom), c.turn_clockwise});
    write_reg(CFG_DURATION, {16'($urandom), c.duration_ms});
    write_reg(CFG_GAIN_P, c.gain_p);
    write_reg(CFG_GAIN_I, c.gain_i);
    write_reg(CFG_GAIN_D, c.gain_d);
    write_reg(3'(CFG_GAIN_D) + 3'($urandom_range(1, 2)), $urandom);
  endtask

  function automatic logic signed [31:0] random_gain();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return 32'($urandom);
      default: return 32'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.target_angle   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'(int'($urandom_range(0, 120)) - 60);
    c.turn_clockwise = 1'($urandom);
    case ($urandom_range(0, 7))
      0:       c.duration_ms = '0;
      1:       c.duration_ms = 16'hFFFF;
      2:       c.duration_ms = 16'($urandom);
      default: c.duration_ms = 16'($urandom_range(0, 400));
    endcase
    c.gain_p = random_gain();
    c.gain_i = random_gain();
    c.gain_d = random_gain();
    return c;
  endfunction

  // Mostly a heading that settles near the target, so the error stays small and the power
  // is often below full scale; now and then a wide swing or a sample from anywhere.
  function automatic logic signed [23:0] pick_sample(logic signed [23:0] base);
    int noise;
    noise = int'($urandom_range(0, 4096)) - 2048;
    case ($urandom_range(0, 9))
      0:       return 24'($urandom);
      1, 2:    return base + 24'(noise * 64);
      default: return base + 24'(int'(signed'(cur_cfg.target_angle)) * 256 - noise);
    endcase
  endfunction

  initial begin
    cfg_t               c;
    logic signed [23:0] base;
    int unsigned        run_len;
    int unsigned        phase_end;
    power_chk = new();
    cur_cfg   = power_chk.regs;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= '0;
    cfg_data_i            <= '0;
    req_if.valid          <= 1'b0;
    req_if.operation      <= OP_START;
    req_if.heading_sample <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with light idling on both sides.
    send_idle_pct = 10;
    recv_idle_pct = 10;

    // Reset registers give a zero-length window: a tick before any start is already done.
    send_request(OP_TICK, 24'sh7F_FFFF);
    send_request(OP_START, '0);
    drain();

    // Largest target from the most negative tare; full-scale gains drive both saturations.
    // A 30 ms window lets three ticks run, the fourth reports done.
    c = '{target_angle: 16'sh7FFF, turn_clockwise: 1'b1, duration_ms: 16'd30,
          gain_p: 32'sh0001_0000, gain_i: 32'sh7FFF_FFFF, gain_d: 32'sh8000_0000};
    load_config(c);
    send_request(OP_START, 24'sh80_0000);
    send_request(OP_TICK, 24'sh7F_FFFF);
    send_request(OP_TICK, 24'sh80_0000);
    send_request(OP_TICK, '0);
    send_request(OP_TICK, 24'sh7F_FFFF);
    drain();

    // Most negative target, counterclockwise, the longest window and opposite extreme gains.
    c = '{target_angle: 16'sh8000, turn_clockwise: 1'b0, duration_ms: 16'hFFFF,
          gain_p: 32'sh8000_0000, gain_i: '0, gain_d: 32'sh7FFF_FFFF};
    load_config(c);
    send_request(OP_START, 24'sh7F_FFFF);
    send_request(OP_TICK, 24'sh80_0000);
    send_request(OP_TICK, 24'sh7F_FFFF);
    send_request(OP_TICK, 24'sh12_3456);
    send_request(OP_TICK, 24'sh80_0000);
    drain();

    // Small gains that stay below full scale while the heading swings around 45 degrees.
    // The 50 ms window runs five ticks; the last two report done.
    c = '{target_angle: 16'sd45, turn_clockwise: 1'b1, duration_ms: 16'd50,
          gain_p: 32'sh0000_0400, gain_i: 32'sh0000_0010, gain_d: 32'shFFFF_FC00};
    load_config(c);
    send_request(OP_START, 24'sh00_0100);
    send_request(OP_TICK, 24'sh00_0100);
    send_request(OP_TICK, 24'sh00_1100);
    send_request(OP_TICK, 24'sh00_2E00);
    send_request(OP_TICK, 24'sh00_3000);
    send_request(OP_TICK, 24'shFF_F000);
    send_request(OP_TICK, 24'sh00_2E00);
    send_request(OP_TICK, 24'sh00_2E00);

    // Random phases. Each one waits for all results, loads a fresh setting and then sends
    // mostly well-formed turns: a start followed by a run of ticks, often long enough to
    // pass the end of the window. One sequence in ten is a stray start or tick instead.
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      drain();
      if (items_sent >= QUIET_FROM) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(0, 3) * 8;
        recv_idle_pct = $urandom_range(0, 3) * 8;
      end
      load_config(random_config());
      phase_end = items_sent + $urandom_range(30, 80);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) != 0) begin
          base = 24'($urandom);
          send_request(OP_START, base);
          if (cur_cfg.duration_ms <= 400 && $urandom_range(0, 1) == 1) begin
            run_len = cur_cfg.duration_ms / TICK_MS + $urandom_range(1, 4);
          end else begin
            run_len = $urandom_range(1, 40);
          end
          repeat (run_len) send_request(OP_TICK, pick_sample(base));
        end else begin
          send_request(op_e'(1'($urandom)), 24'($urandom));
        end
      end
    end

    // Wait for the last results, then a little longer to catch any extra ones.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (power_chk.mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a block that hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
